FILE: src/prt_pkg.sv
package prt_pkg;

  // field widths
  localparam int COORD_W = 32;
  localparam int TRIG_W  = 16;
  localparam int ANGLE_W = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

  // cordic working format, q.30 with headroom for the unreduced angle
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = 5;
  localparam int ANGLE_SHIFT  = 17;
  localparam int Q14_SHIFT    = 16;
  localparam int Q14_W        = CORDIC_W - Q14_SHIFT;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  localparam logic signed [CORDIC_W-1:0] PI_Q30          = 34'sd3373259426;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30     = 34'sd1686629713;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] ROUND_Q14       = 34'sd32768;

  localparam logic signed [TRIG_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [Q14_W-1:0]  Q14_MAX = 18'sd16384;
  localparam logic signed [Q14_W-1:0]  Q14_MIN = -18'sd16384;

  // rotation datapath rounding, q1.14 products back to q16.16
  localparam int TRIG_FRAC  = 14;
  localparam int ROUND_TRIG = 8192;

  typedef enum logic [1:0] {
    CORDIC_IDLE,
    CORDIC_RUN,
    CORDIC_DONE
  } cordic_state_t;

  // arctangent of 2^-i in q.30, rounded
  function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
    logic signed [CORDIC_W-1:0] r;
    case (i)
      5'd0:    r = 34'sd843314857;
      5'd1:    r = 34'sd497837829;
      5'd2:    r = 34'sd263043837;
      5'd3:    r = 34'sd133525159;
      5'd4:    r = 34'sd67021687;
      5'd5:    r = 34'sd33543516;
      5'd6:    r = 34'sd16775851;
      5'd7:    r = 34'sd8388437;
      5'd8:    r = 34'sd4194283;
      5'd9:    r = 34'sd2097149;
      5'd10:   r = 34'sd1048576;
      // small angles: the arctangent rounds to the angle itself
      default: r = CORDIC_W'(34'sd1 <<< (5'd30 - i));
    endcase
    return r;
  endfunction

  // q.30 to q1.14, round half up, clamp to plus or minus one
  function automatic logic signed [TRIG_W-1:0] to_q14(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    logic signed [Q14_W-1:0]    q;
    logic signed [Q14_W-1:0]    c;
    r = v + ROUND_Q14;
    q = r[CORDIC_W-1:Q14_SHIFT];
    if (q > Q14_MAX) begin
      c = Q14_MAX;
    end else if (q < Q14_MIN) begin
      c = Q14_MIN;
    end else begin
      c = q;
    end
    return c[TRIG_W-1:0];
  endfunction

endpackage

FILE: src/prt_in_if.sv
interface prt_in_if import prt_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic signed [COORD_W-1:0] in_z;
  logic [COORD_W-1:0]        in_intensity;

  modport source (
    output valid, in_x, in_y, in_z, in_intensity,
    input  ready
  );

  modport sink (
    input  valid, in_x, in_y, in_z, in_intensity,
    output ready
  );

endinterface

FILE: src/prt_out_if.sv
interface prt_out_if import prt_pkg::*; ();

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [COORD_W-1:0]        out_intensity;

  modport source (
    output valid, out_x, out_y, out_z, out_intensity,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, out_intensity,
    output ready
  );

endinterface

FILE: src/point_rigid_transform.sv
// Rigid transform of a point stream: each point is rotated by yaw about z, then roll about x,
// then pitch about y, then translated, with the intensity word carried alongside. The datapath
// is a seven-stage pipeline taking one point per clock unless output or trig refresh stalls it;
// each stage holds one rank of 16-bit by up to 38-bit multipliers or one wide add, and stages
// with no valid point fill while the output is held, so the input keeps flowing until the
// pipeline is full. Angle writes start an iterative CORDIC (one step per cycle, 30 steps) that
// refreshes the cached Q1.14 sine and cosine; the input is held off from the angle write until
// every stale axis is refreshed. Coordinate results saturate to the signed 32-bit range.
module point_rigid_transform import prt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  prt_in_if.sink               points_in,
  prt_out_if.source            points_out,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  localparam int NSTAGE = 7;
  localparam int P1_W   = COORD_W + TRIG_W;
  localparam int X1_W   = P1_W + 1 - TRIG_FRAC;
  localparam int P3_W   = X1_W + TRIG_W;
  localparam int Y2_W   = P3_W + 1 - TRIG_FRAC;
  localparam int P5_W   = Y2_W + TRIG_W;
  localparam int F_W    = P5_W + 1 - TRIG_FRAC;
  localparam int SUM_W  = F_W + 1;

  // configuration registers
  logic signed [ANGLE_W-1:0] angle [3];
  logic signed [COORD_W-1:0] shift_x;
  logic signed [COORD_W-1:0] shift_y;
  logic signed [COORD_W-1:0] shift_z;

  // cached trig values per axis: roll, pitch, yaw
  logic signed [TRIG_W-1:0] trig_cos [3];
  logic signed [TRIG_W-1:0] trig_sin [3];

  // cordic sequencer
  cordic_state_t              state;
  cordic_state_t              state_next;
  logic [2:0]                 dirty;
  logic [2:0]                 dirty_set;
  logic [2:0]                 dirty_clr;
  logic [1:0]                 pick_slot;
  logic                       angle_wr;
  logic                       cor_load;
  logic                       cor_run;
  logic                       cor_write;
  logic [STEP_W-1:0]          cor_step;
  logic [1:0]                 cor_slot;
  logic                       cor_flip;
  logic signed [CORDIC_W-1:0] cor_x;
  logic signed [CORDIC_W-1:0] cor_y;
  logic signed [CORDIC_W-1:0] cor_z;
  logic signed [CORDIC_W-1:0] z_wide;
  logic signed [CORDIC_W-1:0] z_red;
  logic                       flip;
  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [CORDIC_W-1:0] x_fin;
  logic signed [CORDIC_W-1:0] y_fin;

  // pipeline control
  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] adv;
  logic              trig_ready;
  logic              in_fire;

  // pipeline payload
  logic signed [P1_W-1:0]    s1_cx;
  logic signed [P1_W-1:0]    s1_sy;
  logic signed [P1_W-1:0]    s1_sx;
  logic signed [P1_W-1:0]    s1_cy;
  logic signed [COORD_W-1:0] s1_z;
  logic [COORD_W-1:0]        s1_int;
  logic signed [X1_W-1:0]    s2_x1;
  logic signed [X1_W-1:0]    s2_y1;
  logic signed [COORD_W-1:0] s2_z;
  logic [COORD_W-1:0]        s2_int;
  logic signed [P3_W-1:0]    s3_cy;
  logic signed [P3_W-1:0]    s3_sz;
  logic signed [P3_W-1:0]    s3_sy;
  logic signed [P3_W-1:0]    s3_cz;
  logic signed [X1_W-1:0]    s3_x1;
  logic [COORD_W-1:0]        s3_int;
  logic signed [Y2_W-1:0]    s4_y2;
  logic signed [Y2_W-1:0]    s4_z2;
  logic signed [X1_W-1:0]    s4_x1;
  logic [COORD_W-1:0]        s4_int;
  logic signed [P5_W-1:0]    s5_cx;
  logic signed [P5_W-1:0]    s5_sz;
  logic signed [P5_W-1:0]    s5_sx;
  logic signed [P5_W-1:0]    s5_cz;
  logic signed [Y2_W-1:0]    s5_y2;
  logic [COORD_W-1:0]        s5_int;
  logic signed [F_W-1:0]     s6_fx;
  logic signed [F_W-1:0]     s6_fz;
  logic signed [Y2_W-1:0]    s6_y2;
  logic [COORD_W-1:0]        s6_int;
  logic signed [COORD_W-1:0] s7_x;
  logic signed [COORD_W-1:0] s7_y;
  logic signed [COORD_W-1:0] s7_z;
  logic [COORD_W-1:0]        s7_int;

  logic signed [P1_W:0]  s2_xs;
  logic signed [P1_W:0]  s2_ys;
  logic signed [P3_W:0]  s4_ys;
  logic signed [P3_W:0]  s4_zs;
  logic signed [P5_W:0]  s6_xs;
  logic signed [P5_W:0]  s6_zs;
  logic signed [SUM_W-1:0] s7_xs;
  logic signed [SUM_W-1:0] s7_ys;
  logic signed [SUM_W-1:0] s7_zs;

  // clamp a wide sum to the signed 32-bit range
  function automatic logic [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v[SUM_W-1] && !(&v[SUM_W-2:COORD_W-1])) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else if (!v[SUM_W-1] && (|v[SUM_W-2:COORD_W-1])) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  // configuration decode
  assign angle_wr = cfg_write &&
                    (cfg_index == REG_ROLL || cfg_index == REG_PITCH || cfg_index == REG_YAW);
  assign dirty_set = angle_wr ? 3'(3'b001 << cfg_index[1:0]) : 3'b000;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle[0] <= '0;
      angle[1] <= '0;
      angle[2] <= '0;
      shift_x  <= '0;
      shift_y  <= '0;
      shift_z  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROLL:    angle[0] <= cfg_data[ANGLE_W-1:0];
        REG_PITCH:   angle[1] <= cfg_data[ANGLE_W-1:0];
        REG_YAW:     angle[2] <= cfg_data[ANGLE_W-1:0];
        REG_SHIFT_X: shift_x  <= cfg_data;
        REG_SHIFT_Y: shift_y  <= cfg_data;
        REG_SHIFT_Z: shift_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pick the lowest axis whose trig values are stale
  always_comb begin
    if (dirty[0]) begin
      pick_slot = 2'd0;
    end else if (dirty[1]) begin
      pick_slot = 2'd1;
    end else begin
      pick_slot = 2'd2;
    end
  end

  assign dirty_clr = cor_load ? 3'(3'b001 << pick_slot) : 3'b000;

  // a rewrite during a run marks the axis stale again
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= '0;
    end else begin
      dirty <= (dirty & ~dirty_clr) | dirty_set;
    end
  end

  // angle into q.30, folded into plus or minus half pi
  always_comb begin
    z_wide = {angle[pick_slot][ANGLE_W-1], angle[pick_slot], {ANGLE_SHIFT{1'b0}}};
    flip   = 1'b0;
    z_red  = z_wide;
    if (z_wide > HALF_PI_Q30) begin
      z_red = z_wide - PI_Q30;
      flip  = 1'b1;
    end else if (z_wide < -HALF_PI_Q30) begin
      z_red = z_wide + PI_Q30;
      flip  = 1'b1;
    end
  end

  // cordic sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORDIC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cor_load   = 1'b0;
    cor_run    = 1'b0;
    cor_write  = 1'b0;
    case (state)
      CORDIC_IDLE: begin
        if (dirty != 3'b000) begin
          cor_load   = 1'b1;
          state_next = CORDIC_RUN;
        end
      end
      CORDIC_RUN: begin
        cor_run = 1'b1;
        if (cor_step == STEP_LAST) begin
          state_next = CORDIC_DONE;
        end
      end
      CORDIC_DONE: begin
        cor_write  = 1'b1;
        state_next = CORDIC_IDLE;
      end
      default: begin
        state_next = CORDIC_IDLE;
      end
    endcase
  end

  // one rotation step per cycle
  assign dx = cor_y >>> cor_step;
  assign dy = cor_x >>> cor_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cor_step <= '0;
    end else if (cor_load) begin
      cor_step <= '0;
    end else if (cor_run) begin
      cor_step <= cor_step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cor_load) begin
      cor_x    <= CORDIC_GAIN_Q30;
      cor_y    <= '0;
      cor_z    <= z_red;
      cor_slot <= pick_slot;
      cor_flip <= flip;
    end else if (cor_run) begin
      if (!cor_z[CORDIC_W-1]) begin
        cor_x <= cor_x - dx;
        cor_y <= cor_y + dy;
        cor_z <= cor_z - atan_q30(cor_step);
      end else begin
        cor_x <= cor_x + dx;
        cor_y <= cor_y - dy;
        cor_z <= cor_z + atan_q30(cor_step);
      end
    end
  end

  // trig cache, cosines reset to one and sines to zero
  assign x_fin = cor_flip ? -cor_x : cor_x;
  assign y_fin = cor_flip ? -cor_y : cor_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_cos[0] <= ONE_Q14;
      trig_cos[1] <= ONE_Q14;
      trig_cos[2] <= ONE_Q14;
      trig_sin[0] <= '0;
      trig_sin[1] <= '0;
      trig_sin[2] <= '0;
    end else if (cor_write) begin
      trig_cos[cor_slot] <= to_q14(x_fin);
      trig_sin[cor_slot] <= to_q14(y_fin);
    end
  end

  // stage advance: a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[NSTAGE-1] = !vld[NSTAGE-1] || points_out.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign trig_ready      = (state == CORDIC_IDLE) && (dirty == 3'b000) && !angle_wr;
  assign points_in.ready = adv[0] && trig_ready;
  assign in_fire         = points_in.valid && points_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_fire;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: yaw products
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_cx  <= P1_W'(points_in.in_x) * P1_W'(trig_cos[2]);
      s1_sy  <= P1_W'(points_in.in_y) * P1_W'(trig_sin[2]);
      s1_sx  <= P1_W'(points_in.in_x) * P1_W'(trig_sin[2]);
      s1_cy  <= P1_W'(points_in.in_y) * P1_W'(trig_cos[2]);
      s1_z   <= points_in.in_z;
      s1_int <= points_in.in_intensity;
    end
  end

  // stage 2: yaw sums, rounded to q16.16
  always_comb begin
    s2_xs = (P1_W+1)'(s1_cx) - (P1_W+1)'(s1_sy) + (P1_W+1)'(ROUND_TRIG);
    s2_ys = (P1_W+1)'(s1_sx) + (P1_W+1)'(s1_cy) + (P1_W+1)'(ROUND_TRIG);
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_x1  <= s2_xs[P1_W:TRIG_FRAC];
      s2_y1  <= s2_ys[P1_W:TRIG_FRAC];
      s2_z   <= s1_z;
      s2_int <= s1_int;
    end
  end

  // stage 3: roll products
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_cy  <= P3_W'(s2_y1) * P3_W'(trig_cos[0]);
      s3_sz  <= P3_W'(s2_z) * P3_W'(trig_sin[0]);
      s3_sy  <= P3_W'(s2_y1) * P3_W'(trig_sin[0]);
      s3_cz  <= P3_W'(s2_z) * P3_W'(trig_cos[0]);
      s3_x1  <= s2_x1;
      s3_int <= s2_int;
    end
  end

  // stage 4: roll sums
  always_comb begin
    s4_ys = (P3_W+1)'(s3_cy) - (P3_W+1)'(s3_sz) + (P3_W+1)'(ROUND_TRIG);
    s4_zs = (P3_W+1)'(s3_sy) + (P3_W+1)'(s3_cz) + (P3_W+1)'(ROUND_TRIG);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_y2  <= s4_ys[P3_W:TRIG_FRAC];
      s4_z2  <= s4_zs[P3_W:TRIG_FRAC];
      s4_x1  <= s3_x1;
      s4_int <= s3_int;
    end
  end

  // stage 5: pitch products
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_cx  <= P5_W'(s4_x1) * P5_W'(trig_cos[1]);
      s5_sz  <= P5_W'(s4_z2) * P5_W'(trig_sin[1]);
      s5_sx  <= P5_W'(s4_x1) * P5_W'(trig_sin[1]);
      s5_cz  <= P5_W'(s4_z2) * P5_W'(trig_cos[1]);
      s5_y2  <= s4_y2;
      s5_int <= s4_int;
    end
  end

  // stage 6: pitch sums
  always_comb begin
    s6_xs = (P5_W+1)'(s5_cx) + (P5_W+1)'(s5_sz) + (P5_W+1)'(ROUND_TRIG);
    s6_zs = (P5_W+1)'(s5_cz) - (P5_W+1)'(s5_sx) + (P5_W+1)'(ROUND_TRIG);
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_fx  <= s6_xs[P5_W:TRIG_FRAC];
      s6_fz  <= s6_zs[P5_W:TRIG_FRAC];
      s6_y2  <= s5_y2;
      s6_int <= s5_int;
    end
  end

  // stage 7: translation and saturation into the output register
  always_comb begin
    s7_xs = SUM_W'(s6_fx) + SUM_W'(shift_x);
    s7_ys = SUM_W'(s6_y2) + SUM_W'(shift_y);
    s7_zs = SUM_W'(s6_fz) + SUM_W'(shift_z);
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_x   <= sat32(s7_xs);
      s7_y   <= sat32(s7_ys);
      s7_z   <= sat32(s7_zs);
      s7_int <= s6_int;
    end
  end

  assign points_out.valid         = vld[NSTAGE-1];
  assign points_out.out_x         = s7_x;
  assign points_out.out_y         = s7_y;
  assign points_out.out_z         = s7_z;
  assign points_out.out_intensity = s7_int;

  // an angle write always leaves a trig refresh pending or running
  a_angle_pending: assert property (@(posedge clk) disable iff (rst)
    angle_wr |=> (dirty != 3'b000) || (state != CORDIC_IDLE))
    else $error("angle write left no trig refresh");

  // the last rotation step hands over to the cache write
  a_run_length: assert property (@(posedge clk) disable iff (rst)
    (state == CORDIC_RUN) && (cor_step == STEP_LAST) |=> (state == CORDIC_DONE))
    else $error("cordic run did not end after the last step");

  // a cached cosine never leaves the range of plus or minus one
  a_cos_bound: assert property (@(posedge clk) disable iff (rst)
    cor_write |=> (trig_cos[cor_slot] <= ONE_Q14) && (trig_cos[cor_slot] >= -ONE_Q14))
    else $error("cached cosine out of range");

  // an accepted transaction occupies the first stage
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> vld[0])
    else $error("accepted transaction missing from first stage");

endmodule
